>>> hdl/clcd_pkg.sv
// Shared types, codes and init tables for the character LCD write controller.
package clcd_pkg;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_CMD    = 3'd1,
		OP_CHAR   = 3'd2,
		OP_CURSOR = 3'd3,
		OP_INIT   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_FOUR_BIT    = 2'd0,
		REG_ENABLE_HIGH = 2'd1,
		REG_SETTLE      = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_EN_HIGH = 3'b010,
		PH_EN_LOW  = 3'b100
	} phase_t;

	localparam logic [15:0] ENABLE_HIGH_RESET = 16'd1000;
	localparam logic [15:0] SETTLE_RESET      = 16'd5000;
	localparam logic [7:0]  ROW0_BASE         = 8'h80;
	localparam logic [7:0]  ROW1_BASE         = 8'hC0;
	localparam logic [3:0]  INIT4_LEN         = 4'd7;
	localparam logic [3:0]  INIT8_LEN         = 4'd5;

	typedef struct packed {
		logic        four_bit_mode;
		logic [15:0] enable_high_ticks;
		logic [15:0] settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [5:0] column;
		logic       row;
		logic [7:0] value;
		logic [2:0] operation;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic       busy_res;
		logic [7:0] bus_value;
		logic       enable_pin;
		logic       reg_select;
	} result_t;

	// Command byte of one init step; steps past the end read as zero.
	function automatic logic [7:0] init_byte(input logic four_bit, input logic [2:0] step);
		logic [7:0] b;
		b = 8'h00;
		if (four_bit) begin
			unique case (step)
				3'd0: b = 8'h33;
				3'd1: b = 8'h32;
				3'd2: b = 8'h28;
				3'd3: b = 8'h0C;
				3'd4: b = 8'h01;
				3'd5: b = 8'h06;
				3'd6: b = 8'h02;
				default: b = 8'h00;
			endcase
		end else begin
			unique case (step)
				3'd0: b = 8'h38;
				3'd1: b = 8'h0C;
				3'd2: b = 8'h01;
				3'd3: b = 8'h06;
				3'd4: b = 8'h02;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

>>> hdl/clcd_engine.sv
// Transfer sequencer: pin state, tick counting and init stepping, one item per cycle while fire is high.
module clcd_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  clcd_pkg::cfg_t    cfg,
	input  logic              fire,
	input  clcd_pkg::item_t   item,
	output clcd_pkg::result_t res
);
	import clcd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [7:0]  pending_q, pending_d;
	logic        second_q, second_d;
	logic [2:0]  step_q, step_d;
	logic        init_run_q, init_run_d;
	logic        rs_q, rs_d;
	logic [7:0]  bus_q, bus_d;

	always_comb begin
		logic [15:0] cnt;
		logic [15:0] hi_lim;
		logic [15:0] lo_lim;
		logic [3:0]  init_len;
		logic        start;
		logic [7:0]  sb;
		logic        srs;
		logic        acc;
		logic        is_req;
		phase_d    = phase_q;
		tick_d     = tick_q;
		pending_d  = pending_q;
		second_d   = second_q;
		step_d     = step_q;
		init_run_d = init_run_q;
		rs_d       = rs_q;
		bus_d      = bus_q;
		hi_lim     = (cfg.enable_high_ticks == 16'd0) ? 16'd1 : cfg.enable_high_ticks;
		lo_lim     = (cfg.settle_ticks == 16'd0) ? 16'd1 : cfg.settle_ticks;
		init_len   = cfg.four_bit_mode ? INIT4_LEN : INIT8_LEN;
		cnt        = tick_q + 16'd1;
		start      = 1'b0;
		sb         = 8'h00;
		srs        = 1'b0;
		acc        = 1'b0;
		is_req     = (item.operation == OP_CMD) || (item.operation == OP_CHAR) ||
			(item.operation == OP_CURSOR) || (item.operation == OP_INIT);

		priority if (item.operation == OP_TICK) begin
			unique case (phase_q)
				PH_EN_HIGH: begin
					tick_d = cnt;
					if (cnt >= hi_lim) begin
						tick_d  = 16'd0;
						phase_d = PH_EN_LOW;
					end
				end
				PH_EN_LOW: begin
					tick_d = cnt;
					if (cnt >= lo_lim) begin
						tick_d = 16'd0;
						priority if (second_q) begin
							// low nibble of the same byte
							second_d = 1'b0;
							bus_d    = {1'b0, pending_q[3:0], 3'b000};
							phase_d  = PH_EN_HIGH;
						end else if (init_run_q && ({1'b0, step_q} + 4'd1 < init_len)) begin
							step_d = step_q + 3'd1;
							start  = 1'b1;
							sb     = init_byte(cfg.four_bit_mode, step_q + 3'd1);
						end else begin
							init_run_d = 1'b0;
							step_d     = 3'd0;
							phase_d    = PH_IDLE;
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end else if (is_req && phase_q == PH_IDLE) begin
			acc   = 1'b1;
			start = 1'b1;
			unique case (item.operation)
				OP_CMD:  sb = item.value;
				OP_CHAR: begin
					sb  = item.value;
					srs = 1'b1;
				end
				OP_CURSOR: sb = (item.row ? ROW1_BASE : ROW0_BASE) + {2'b00, item.column};
				default: begin
					init_run_d = 1'b1;
					step_d     = 3'd0;
					sb         = init_byte(cfg.four_bit_mode, 3'd0);
				end
			endcase
		end else begin
			// rejected request or unused code: hold
		end

		if (start) begin
			pending_d = sb;
			rs_d      = srs;
			bus_d     = cfg.four_bit_mode ? {1'b0, sb[7:4], 3'b000} : sb;
			second_d  = cfg.four_bit_mode;
			tick_d    = 16'd0;
			phase_d   = PH_EN_HIGH;
		end

		res.reg_select = rs_d;
		res.enable_pin = (phase_d == PH_EN_HIGH);
		res.bus_value  = bus_d;
		res.busy_res   = (phase_d != PH_IDLE);
		res.accepted   = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= 16'd0;
			pending_q  <= 8'h00;
			second_q   <= 1'b0;
			step_q     <= 3'd0;
			init_run_q <= 1'b0;
			rs_q       <= 1'b0;
			bus_q      <= 8'h00;
		end else if (fire) begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			pending_q  <= pending_d;
			second_q   <= second_d;
			step_q     <= step_d;
			init_run_q <= init_run_d;
			rs_q       <= rs_d;
			bus_q      <= bus_d;
		end
	end

endmodule

>>> hdl/char_lcd_write_controller_unit.sv
// Top level of the character LCD write controller: stream ports, config registers, pipeline.
//
// Each beat on the slave side is one timebase tick or one request (command byte, character
// byte, cursor move, init sequence) and yields exactly one result beat that shows the RS,
// enable and data pin levels after the beat has been applied, plus busy and an accepted
// flag. The block takes one beat per clock unless m_tready stalls the output; a beat waits
// in the input register and its result enters the output register once it is processed.
// The output register lets a new beat enter while a result still waits on m_tready.
// Requests arriving while a transfer or the init sequence runs are dropped with accepted
// low. Write the configuration registers only while no beat is in flight.
module char_lcd_write_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // value[7:0], row[8], column[14:9], zero[15]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // reg_select[0], enable_pin[1], bus_value[9:2],
	                               // busy_res[10], accepted[11], zero[15:12]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import clcd_pkg::*;

	cfg_t    cfg_q;
	logic    v_s1;
	item_t   item_s1;
	logic    advance;
	logic    fire;
	result_t res;
	logic    m_tvalid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_mode     <= 1'b1;
			cfg_q.enable_high_ticks <= ENABLE_HIGH_RESET;
			cfg_q.settle_ticks      <= SETTLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOUR_BIT:    cfg_q.four_bit_mode     <= cfg_wdata[0];
				REG_ENABLE_HIGH: cfg_q.enable_high_ticks <= cfg_wdata;
				REG_SETTLE:      cfg_q.settle_ticks      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance  = !m_tvalid_q || m_tready;
	assign fire     = v_s1 && advance;
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation <= s_tuser;
			item_s1.value     <= s_tdata[7:0];
			item_s1.row       <= s_tdata[8];
			item_s1.column    <= s_tdata[14:9];
		end
	end

	clcd_engine u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.fire  (fire),
		.item  (item_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, res_q};

	// A taken request always starts a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && res_q.accepted |-> res_q.busy_res)
		else $error("accepted result without busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && res_q.enable_pin |-> res_q.busy_res)
		else $error("enable high while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.accepted |->
			(item_s1.operation == OP_CMD) || (item_s1.operation == OP_CHAR) ||
			(item_s1.operation == OP_CURSOR) || (item_s1.operation == OP_INIT))
		else $error("non-request beat marked accepted");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid_q)
		else $error("processed beat produced no result");

endmodule
